// ----- sv/mbup_pkg.sv -----
`timescale 1ns / 1ps
// mbup_pkg: types and constants shared by the MIDI byte to USB-MIDI packet encoder
// no dependencies

package mbup_pkg;

    // MIDI byte classes and special status bytes
    localparam logic [7:0] STATUS_NONE    = 8'h00;
    localparam logic [7:0] REALTIME_FIRST = 8'hF8;
    localparam logic [7:0] SYSEX_START    = 8'hF0;
    localparam logic [7:0] SYSEX_END      = 8'hF7;
    localparam logic [7:0] TUNE_REQUEST   = 8'hF6;
    localparam logic [7:0] SONG_POSITION  = 8'hF2;
    localparam logic [7:0] BUS_SELECT     = 8'hF5;
    localparam logic [7:0] PROG_CHANGE    = 8'hC0;
    localparam logic [7:0] PITCH_BEND     = 8'hE0;

    // code index numbers
    localparam logic [3:0] CIN_COMMON2    = 4'h2;
    localparam logic [3:0] CIN_COMMON3    = 4'h3;
    localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
    localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
    localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
    localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;
    localparam logic [3:0] CIN_REALTIME   = 4'hF;

    // parser phase, one-hot
    typedef enum logic [5:0] {
        PH_EMPTY     = 6'b000001,
        PH_FULL      = 6'b000010,
        PH_FULLCLEAR = 6'b000100,
        PH_SYSEX0    = 6'b001000,
        PH_SYSEX1    = 6'b010000,
        PH_SYSEX2    = 6'b100000
    } phase_t;

    // parser state carried between items
    typedef struct packed {
        logic [7:0] status;
        phase_t     phase;
        logic [7:0] held_first;
        logic [7:0] held_second;
    } parse_state_t;

    // one result item
    typedef struct packed {
        logic       valid;
        logic [3:0] cin;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } packet_t;

endpackage

// ----- sv/midi_bytes_to_usb_packet.sv -----
`timescale 1ns / 1ps
// midi_bytes_to_usb_packet: serial MIDI bytes to USB-MIDI event packets, cable 0
// depends on mbup_pkg and mbup_decode
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | midi_byte
//  out     | out_valid / out_stall| packet_valid, code_index, event_byte0..2
//
// every accepted byte gives exactly one result item, passing the input register and then the result register
// one byte per cycle sustained while out_stall is low: input register, decode, result register
// parser state updates as an item moves from the input register to the result register
// rst_n clears valids and parser state; payload registers are not reset
// out_stall holds the result; the input register still fills while it is empty

module midi_bytes_to_usb_packet (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] midi_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       packet_valid,
    output logic [3:0] code_index,
    output logic [7:0] event_byte0,
    output logic [7:0] event_byte1,
    output logic [7:0] event_byte2
);
    import mbup_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   byte_reg;
    logic         out_valid_reg;
    packet_t      pkt_reg;
    packet_t      pkt_next;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_free;
    logic         advance;

    // handshake control
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            byte_reg <= midi_byte;
    end

    // packet decode
    mbup_decode u_decode (
        .midi_byte (byte_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .pkt       (pkt_next)
    );

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{STATUS_NONE, PH_EMPTY, 8'h00, 8'h00};
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            pkt_reg <= pkt_next;
    end

    assign out_valid    = out_valid_reg;
    assign packet_valid = pkt_reg.valid;
    assign code_index   = pkt_reg.cin;
    assign event_byte0  = pkt_reg.byte0;
    assign event_byte1  = pkt_reg.byte1;
    assign event_byte2  = pkt_reg.byte2;

    // an empty result carries all-zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !packet_valid) |->
            (code_index == 4'h0 && event_byte0 == 8'h00 &&
             event_byte1 == 8'h00 && event_byte2 == 8'h00))
        else $error("empty result with nonzero fields");

    // real-time packets carry a real-time byte
    a_realtime_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && packet_valid && code_index == CIN_REALTIME) |->
            (event_byte0 >= REALTIME_FIRST))
        else $error("real-time code with non real-time byte");

    // a held item is neither lost nor decoded twice
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(byte_reg)
            && $stable(state_reg)))
        else $error("held input item changed");

    // parser state only moves with a decoded item
    a_state_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("parser state changed without an item");

endmodule

// ----- sv/mbup_decode.sv -----
`timescale 1ns / 1ps
// mbup_decode: combinational next-state and packet logic for one MIDI byte
// depends on mbup_pkg

module mbup_decode (
    input  logic [7:0]            midi_byte,
    input  mbup_pkg::parse_state_t cur,
    output mbup_pkg::parse_state_t nxt,
    output mbup_pkg::packet_t      pkt
);
    import mbup_pkg::*;

    logic [7:0] st;

    assign st = cur.status;

    always_comb
    begin
        nxt = cur;
        pkt = '0;
        if (midi_byte >= REALTIME_FIRST)
        begin
            // real-time passes straight through, state untouched
            pkt = '{1'b1, CIN_REALTIME, midi_byte, 8'h00, 8'h00};
        end
        else if (midi_byte[7])
        begin
            // status byte
            nxt.status = midi_byte;
            if (midi_byte == SYSEX_START)
            begin
                nxt.phase      = PH_SYSEX1;
                nxt.held_first = midi_byte;
            end
            else
            begin
                if (midi_byte == TUNE_REQUEST)
                begin
                    pkt        = '{1'b1, CIN_SYSEX_END1, midi_byte, 8'h00, 8'h00};
                    nxt.status = STATUS_NONE;
                end
                else if (midi_byte == SYSEX_END)
                begin
                    // close sysex with whatever is held; stray end gives nothing
                    if (cur.phase == PH_SYSEX0)
                        pkt = '{1'b1, CIN_SYSEX_END1, midi_byte, 8'h00, 8'h00};
                    else if (cur.phase == PH_SYSEX1)
                        pkt = '{1'b1, CIN_SYSEX_END2, cur.held_first, midi_byte, 8'h00};
                    else if (cur.phase == PH_SYSEX2)
                        pkt = '{1'b1, CIN_SYSEX_END3, cur.held_first, cur.held_second,
                                midi_byte};
                    nxt.status = STATUS_NONE;
                end
                nxt.phase = PH_EMPTY;
            end
        end
        else
        begin
            // data byte
            unique case (cur.phase)
                PH_EMPTY:
                begin
                    if (st == STATUS_NONE)
                    begin
                        // no status, byte dropped
                    end
                    else if (st < PROG_CHANGE || (st >= PITCH_BEND && st < SYSEX_START))
                    begin
                        nxt.phase      = PH_FULL;
                        nxt.held_first = midi_byte;
                    end
                    else if (st < PITCH_BEND)
                    begin
                        pkt = '{1'b1, st[7:4], st, midi_byte, 8'h00};
                    end
                    else if (st == SONG_POSITION || st == BUS_SELECT)
                    begin
                        nxt.phase      = PH_FULLCLEAR;
                        nxt.held_first = midi_byte;
                    end
                    else
                    begin
                        pkt        = '{1'b1, CIN_COMMON2, st, midi_byte, 8'h00};
                        nxt.status = STATUS_NONE;
                    end
                end
                PH_FULL:
                begin
                    nxt.phase = PH_EMPTY;
                    pkt       = '{1'b1, st[7:4], st, cur.held_first, midi_byte};
                end
                PH_FULLCLEAR:
                begin
                    nxt.phase  = PH_EMPTY;
                    nxt.status = STATUS_NONE;
                    pkt        = '{1'b1, CIN_COMMON3, st, cur.held_first, midi_byte};
                end
                PH_SYSEX0:
                begin
                    nxt.phase      = PH_SYSEX1;
                    nxt.held_first = midi_byte;
                end
                PH_SYSEX1:
                begin
                    nxt.phase       = PH_SYSEX2;
                    nxt.held_second = midi_byte;
                end
                PH_SYSEX2:
                begin
                    nxt.phase = PH_SYSEX0;
                    pkt       = '{1'b1, CIN_SYSEX_CONT, cur.held_first, cur.held_second,
                                  midi_byte};
                end
                default:
                begin
                    // unused codes: data ignored
                end
            endcase
        end
    end

endmodule
